### rtl/fdt_pkg.sv
`default_nettype none

package fdt_pkg;

  // One input beat: raw float32, mode select and digit count
  typedef struct packed {
    logic [31:0] value_bits;
    logic        operation;
    logic [3:0]  digit_count;
  } in_item_t;

  // One output beat: one ASCII character and the end-of-text flag
  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_item_t;

  localparam int unsigned Digits       = 19;  // decimal digits of 2^63-1
  localparam int unsigned DivSteps     = 7;   // 56-bit dividend, one byte per step
  localparam int unsigned BcdSteps     = 21;  // 63 bits, three per step
  localparam int unsigned IntDigitScan = 12;
  localparam int unsigned SigLimit     = 9;

  localparam logic [7:0] ExpOne  = 8'd127;   // biased exponent of 1.0
  localparam logic [7:0] ExpHalf = 8'd126;   // biased exponent of 0.5
  localparam logic [7:0] ExpInt  = 8'd150;   // exponent where the ulp is 1

  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [6:0] CharDot   = 7'h2E;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_SIGN,
    EMIT_WHOLE,
    EMIT_DOT,
    EMIT_FRAC,
    EMIT_SPEC
  } emit_e;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_UP,
    IDX_DOWN,
    IDX_HI,
    IDX_DECM1
  } idx_op_e;

  // Controller to datapath
  typedef struct packed {
    logic    load;
    logic    div_load;
    logic    div_step;
    logic    div_round;
    logic    dec_set;
    logic    mul;
    logic    prnd;
    logic    add;
    logic    conv;
    logic    bcd_step;
    logic    scan;
    idx_op_e idx_op;
    emit_e   emit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic special;
    logic neg;
    logic gen_ge1;
    logic scan_ge1;
    logic idig_full;
    logic idx_at_dec;
    logic idx_at_lo;
    logic spec_end;
    logic show_dot;
    logic out_free;
  } status_t;

  // Exact float32 powers of ten, 10^0 .. 10^9
  function automatic logic [31:0] pow10_bits(input logic [3:0] d);
    logic [31:0] r;
    unique case (d)
      4'd0:    r = 32'h3F80_0000;
      4'd1:    r = 32'h4120_0000;
      4'd2:    r = 32'h42C8_0000;
      4'd3:    r = 32'h447A_0000;
      4'd4:    r = 32'h461C_4000;
      4'd5:    r = 32'h47C3_5000;
      4'd6:    r = 32'h4974_2400;
      4'd7:    r = 32'h4B18_9680;
      4'd8:    r = 32'h4CBE_BC20;
      4'd9:    r = 32'h4E6E_6B28;
      default: r = 32'h3F80_0000;
    endcase
    return r;
  endfunction

  // Text of "nan" or "inf" by position
  function automatic logic [6:0] spec_char(input logic is_nan, input logic [1:0] pos);
    logic [6:0] c;
    unique case (pos)
      2'd0:    c = is_nan ? 7'h6E : 7'h69;
      2'd1:    c = is_nan ? 7'h61 : 7'h6E;
      2'd2:    c = is_nan ? 7'h6E : 7'h66;
      default: c = 7'h3F;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/float_to_decimal_text.sv
// float_to_decimal_text: formats one float32 as ASCII decimal text.
// Input channel in_valid_i/in_ready_o carries value bits, mode (fixed or
// general) and a digit count. Output channel out_valid_o/out_ready_i carries
// one character per beat, with last set on the final character of a number.
// NaN and infinities give "nan", "inf" and "-inf".
// One item is worked at a time; in_ready_o is high only while idle. The last
// character may still wait in the output register while the next item is
// taken.
// Each item is checked, scaled, converted by double dabble and scanned, then
// gives N characters (1 to 21); NaN and infinities go straight to their
// characters. General mode with a value of 1.0 or more first divides by ten
// (up to 12 float divisions), each of 7 byte steps of a radix-16 divider;
// the binary to decimal conversion runs 21 double-dabble steps of 3 bits.
// A stalled receiver holds the current character; the block waits with it.
// Reset empties the output register and returns the controller to idle.
`default_nettype none

module float_to_decimal_text #(
  parameter int unsigned MAX_DECIMALS = 9
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  fdt_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output fdt_pkg::out_item_t  out_data_o
);

  fdt_pkg::cmd_t    cmd;
  fdt_pkg::status_t status;

  fdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdt_datapath #(
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### rtl/fdt_datapath.sv
`default_nettype none

module fdt_datapath #(
  parameter int unsigned MAX_DECIMALS = 9
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  fdt_pkg::cmd_t       cmd_i,
  input  fdt_pkg::in_item_t   in_data_i,
  output fdt_pkg::status_t    status_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output fdt_pkg::out_item_t  out_data_o
);

  // Captured item
  logic [30:0] mag_q;
  logic        sign_q;
  logic        general_q;
  logic [3:0]  count_q;

  // Integer digit scan
  logic [30:0] scan_q, scan_d;
  logic [3:0]  idig_q;
  logic [55:0] div_sh_q;
  logic [3:0]  rem_q, rem_d;
  logic [55:0] quo_q;
  logic [7:0]  qbyte;

  // Scaling
  logic [3:0]  dec_q, dec_d;
  logic [31:0] p10_bits;
  logic [47:0] prod_q;
  logic [8:0]  pexp_q;
  logic        mtiny_q;
  logic [23:0] pm_q, pm_d;
  logic [7:0]  pe_q, pe_d;
  logic        sat_q, sat_d, tiny_q, tiny_d;
  logic [23:0] rm_q, rm_d;
  logic [7:0]  re_q, re_d;
  logic [62:0] scaled;

  // Decimal conversion and emission
  logic [62:0]      bin_q, bin_d;
  logic [18:0][3:0] bcd_q, bcd_d;
  logic [4:0]       idx_q, idx_d;
  logic [4:0]       hi;
  logic [3:0]       lo_q, lo_d;
  logic             lo_found;
  logic             show_dot_q, show_dot_d;
  logic             out_valid_q;
  fdt_pkg::out_item_t out_q, out_d;

  logic is_nan;
  logic at_dec, at_lo, at_spec_end;

  // Radix-16 long division by ten, two nibbles per step
  always_comb begin
    logic [3:0]  r;
    logic [7:0]  t;
    logic [15:0] m;
    logic [3:0]  qd;
    r = rem_q;
    qbyte = '0;
    for (int j = 0; j < 2; j++) begin
      t = {r, div_sh_q[55 - 4*j -: 4]};
      m = 16'(t) * 16'd205;           // t/10 for t < 160
      qd = m[14:11];
      r = 4'(t - 8'(qd) * 8'd10);
      qbyte[7 - 4*j -: 4] = qd;
    end
    rem_d = r;
  end

  // Normalize and round the quotient to a float32
  always_comb begin
    logic [23:0] mant;
    logic        g, st, up;
    logic [7:0]  e;
    logic [24:0] m25;
    if (quo_q[52]) begin
      mant = quo_q[52:29];
      g    = quo_q[28];
      st   = (|quo_q[27:0]) | (rem_q != 4'd0);
      e    = scan_q[30:23] - 8'd3;
    end else begin
      mant = quo_q[51:28];
      g    = quo_q[27];
      st   = (|quo_q[26:0]) | (rem_q != 4'd0);
      e    = scan_q[30:23] - 8'd4;
    end
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + 25'(up);
    if (m25[24]) begin
      scan_d = {e + 8'd1, 23'd0};
    end else begin
      scan_d = {e, m25[22:0]};
    end
  end

  // Decimal count from mode, digit count and integer digits
  always_comb begin
    logic [3:0] sig, idig_eff, raw;
    if (count_q == 4'd0) begin
      sig = 4'd1;
    end else if (count_q > 4'(fdt_pkg::SigLimit)) begin
      sig = 4'(fdt_pkg::SigLimit);
    end else begin
      sig = count_q;
    end
    idig_eff = (mag_q[30:23] >= fdt_pkg::ExpOne) ? idig_q : 4'd1;
    if (general_q) begin
      raw = (sig > idig_eff) ? sig - idig_eff : 4'd0;
    end else begin
      raw = count_q;
    end
    dec_d = (raw > 4'(MAX_DECIMALS)) ? 4'(MAX_DECIMALS) : raw;
  end

  assign p10_bits = fdt_pkg::pow10_bits(dec_q);

  // Round the product, flag saturation and negligible values
  always_comb begin
    logic [23:0] mant;
    logic        g, st, up;
    logic [1:0]  eadj;
    logic [24:0] m25;
    logic [9:0]  e10;
    if (prod_q[47]) begin
      mant = prod_q[47:24];
      g    = prod_q[23];
      st   = |prod_q[22:0];
      eadj = 2'd1;
    end else begin
      mant = prod_q[46:23];
      g    = prod_q[22];
      st   = |prod_q[21:0];
      eadj = 2'd0;
    end
    up  = g & (st | mant[0]);
    m25 = {1'b0, mant} + 25'(up);
    if (m25[24]) begin
      pm_d = 24'h80_0000;
      eadj = eadj + 2'd1;
    end else begin
      pm_d = m25[23:0];
    end
    e10    = 10'(pexp_q) + 10'(eadj);
    sat_d  = !mtiny_q && (e10 >= 10'd317);       // 2^63 or more
    tiny_d = mtiny_q || (e10 < 10'd128);         // below the normal range
    pe_d   = 8'(e10 - 10'd127);
  end

  // Float32 add of 0.5
  always_comb begin
    logic [23:0] big, lesser, mant;
    logic [7:0]  eb, d, e;
    logic [26:0] lesser27, sh, lost;
    logic        stk, g, rs, up;
    logic [27:0] sum;
    logic [26:0] s;
    logic [24:0] m25;
    if (pe_q >= fdt_pkg::ExpHalf) begin
      big    = pm_q;
      eb     = pe_q;
      lesser = 24'h80_0000;
      d      = pe_q - fdt_pkg::ExpHalf;
    end else begin
      big    = 24'h80_0000;
      eb     = fdt_pkg::ExpHalf;
      lesser = pm_q;
      d      = fdt_pkg::ExpHalf - pe_q;
    end
    lesser27 = {lesser, 3'b000};
    if (d >= 8'd27) begin
      sh   = '0;
      lost = lesser27;
      stk  = 1'b1;
    end else begin
      sh   = lesser27 >> d[4:0];
      lost = lesser27 & ((27'd1 << d[4:0]) - 27'd1);
      stk  = |lost;
    end
    sum = {1'b0, big, 3'b000} + {1'b0, sh[26:1], sh[0] | stk};
    if (sum[27]) begin
      s = {sum[27:2], sum[1] | sum[0]};
      e = eb + 8'd1;
    end else begin
      s = sum[26:0];
      e = eb;
    end
    mant = s[26:3];
    g    = s[2];
    rs   = s[1] | s[0];
    up   = g & (rs | mant[0]);
    m25  = {1'b0, mant} + 25'(up);
    if (m25[24]) begin
      rm_d = 24'h80_0000;
      re_d = e + 8'd1;
    end else begin
      rm_d = m25[23:0];
      re_d = e;
    end
  end

  // Truncate the sum to an integer, saturating at 2^63-1
  always_comb begin
    logic [7:0] sr;
    sr = '0;
    if (sat_q) begin
      scaled = 63'h7FFF_FFFF_FFFF_FFFF;
    end else if (tiny_q) begin
      scaled = '0;
    end else if (re_q >= fdt_pkg::ExpInt) begin
      sr     = re_q - fdt_pkg::ExpInt;
      scaled = 63'(rm_q) << sr[5:0];
    end else begin
      sr = fdt_pkg::ExpInt - re_q;
      if (sr >= 8'd24) begin
        scaled = '0;
      end else begin
        scaled = 63'(rm_q >> sr[4:0]);
      end
    end
  end

  // Double dabble, three bits per step
  always_comb begin
    logic [18:0][3:0] b;
    logic [62:0]      n;
    b = bcd_q;
    n = bin_q;
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < fdt_pkg::Digits; i++) begin
        if (b[i] >= 4'd5) begin
          b[i] = b[i] + 4'd3;
        end
      end
      b = {b[18][2:0], b[17:0], n[62]};
      n = {n[61:0], 1'b0};
    end
    bcd_d = b;
    bin_d = n;
  end

  // Leading whole digit and last fraction digit: the trailing nonzero one in general mode, the lowest in fixed mode
  always_comb begin
    hi       = 5'(dec_q);
    lo_d     = '0;
    lo_found = 1'b0;
    for (int i = 0; i < fdt_pkg::Digits; i++) begin
      if (5'(i) >= 5'(dec_q) && bcd_q[i] != 4'd0) begin
        hi = 5'(i);
      end
    end
    for (int i = fdt_pkg::Digits - 1; i >= 0; i--) begin
      if (5'(i) < 5'(dec_q) && bcd_q[i] != 4'd0) begin
        lo_d     = 4'(i);
        lo_found = 1'b1;
      end
    end
    if (!general_q) begin
      lo_d = '0;
    end
    show_dot_d = (dec_q != 4'd0) && (!general_q || lo_found);
  end

  // Character pointer
  always_comb begin
    unique case (cmd_i.idx_op)
      fdt_pkg::IDX_HOLD:  idx_d = idx_q;
      fdt_pkg::IDX_ZERO:  idx_d = '0;
      fdt_pkg::IDX_UP:    idx_d = idx_q + 5'd1;
      fdt_pkg::IDX_DOWN:  idx_d = idx_q - 5'd1;
      fdt_pkg::IDX_HI:    idx_d = hi;
      fdt_pkg::IDX_DECM1: idx_d = 5'(dec_q) - 5'd1;
      default:            idx_d = idx_q;
    endcase
  end

  assign is_nan      = mag_q[22:0] != 23'd0;
  assign at_dec      = idx_q == 5'(dec_q);
  assign at_lo       = idx_q == 5'(lo_q);
  assign at_spec_end = idx_q == 5'd2;

  // Character for the current beat
  always_comb begin
    out_d = '0;
    unique case (cmd_i.emit)
      fdt_pkg::EMIT_NONE: out_d = '0;
      fdt_pkg::EMIT_SIGN: out_d = '{character: fdt_pkg::CharMinus, last: 1'b0};
      fdt_pkg::EMIT_WHOLE: begin
        out_d.character = fdt_pkg::CharZero | 7'(bcd_q[idx_q]);
        out_d.last      = at_dec && !show_dot_q;
      end
      fdt_pkg::EMIT_DOT: out_d = '{character: fdt_pkg::CharDot, last: 1'b0};
      fdt_pkg::EMIT_FRAC: begin
        out_d.character = fdt_pkg::CharZero | 7'(bcd_q[idx_q]);
        out_d.last      = at_lo;
      end
      fdt_pkg::EMIT_SPEC: begin
        out_d.character = fdt_pkg::spec_char(is_nan, idx_q[1:0]);
        out_d.last      = at_spec_end;
      end
      default: out_d = '0;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
      idig_q      <= '0;
    end else begin
      idx_q <= idx_d;
      if (cmd_i.emit != fdt_pkg::EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        idig_q <= '0;
      end else if (cmd_i.div_round) begin
        idig_q <= idig_q + 4'd1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q     <= in_data_i.value_bits[30:0];
      sign_q    <= in_data_i.value_bits[31];
      general_q <= in_data_i.operation;
      count_q   <= in_data_i.digit_count;
      scan_q    <= in_data_i.value_bits[30:0];
    end else if (cmd_i.div_round) begin
      scan_q <= scan_d;
    end
    if (cmd_i.div_load) begin
      div_sh_q <= {1'b1, scan_q[22:0], 32'd0};
      rem_q    <= '0;
      quo_q    <= '0;
    end else if (cmd_i.div_step) begin
      div_sh_q <= {div_sh_q[47:0], 8'd0};
      rem_q    <= rem_d;
      quo_q    <= {quo_q[47:0], qbyte};
    end
    if (cmd_i.dec_set) begin
      dec_q <= dec_d;
    end
    if (cmd_i.mul) begin
      prod_q  <= 48'({1'b1, mag_q[22:0]}) * 48'({1'b1, p10_bits[22:0]});
      pexp_q  <= 9'(mag_q[30:23]) + 9'(p10_bits[30:23]);
      mtiny_q <= mag_q[30:23] == 8'd0;
    end
    if (cmd_i.prnd) begin
      pm_q   <= pm_d;
      pe_q   <= pe_d;
      sat_q  <= sat_d;
      tiny_q <= tiny_d;
    end
    if (cmd_i.add) begin
      rm_q <= rm_d;
      re_q <= re_d;
    end
    if (cmd_i.conv) begin
      bin_q <= scaled;
      bcd_q <= '0;
    end else if (cmd_i.bcd_step) begin
      bin_q <= bin_d;
      bcd_q <= bcd_d;
    end
    if (cmd_i.scan) begin
      lo_q       <= lo_d;
      show_dot_q <= show_dot_d;
    end
    if (cmd_i.emit != fdt_pkg::EMIT_NONE) begin
      out_q <= out_d;
    end
  end

  // Status back to the controller
  assign status_o.special    = mag_q[30:23] == 8'hFF;
  assign status_o.neg        = sign_q && (mag_q != 31'd0)
                               && !(mag_q[30:23] == 8'hFF && is_nan);
  assign status_o.gen_ge1    = general_q && (mag_q[30:23] >= fdt_pkg::ExpOne);
  assign status_o.scan_ge1   = scan_q[30:23] >= fdt_pkg::ExpOne;
  assign status_o.idig_full  = idig_q == 4'(fdt_pkg::IntDigitScan);
  assign status_o.idx_at_dec = at_dec;
  assign status_o.idx_at_lo  = at_lo;
  assign status_o.spec_end   = at_spec_end;
  assign status_o.show_dot   = show_dot_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit != fdt_pkg::EMIT_NONE) |-> (!out_valid_q || out_ready_i))
    else $error("character written over a pending beat");

  a_dot_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit == fdt_pkg::EMIT_DOT) |-> show_dot_q)
    else $error("point emitted with no fraction to follow");

  a_whole_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit == fdt_pkg::EMIT_WHOLE) |-> (idx_q >= 5'(dec_q) && idx_q < 5'd19))
    else $error("whole digit pointer out of range");

endmodule

`default_nettype wire

### rtl/fdt_ctrl.sv
`default_nettype none

module fdt_ctrl (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  fdt_pkg::status_t  status_i,
  output fdt_pkg::cmd_t     cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_DIV_CHK,
    S_DIV,
    S_DIV_RND,
    S_DEC,
    S_MUL,
    S_PRND,
    S_ADD,
    S_CONV,
    S_BCD,
    S_SCAN,
    S_SIGN,
    S_SPEC,
    S_WHOLE,
    S_DOT,
    S_FRAC
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.idx_op = fdt_pkg::IDX_HOLD;
    cmd_o.emit   = fdt_pkg::EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (status_i.special) begin
          cmd_o.idx_op = fdt_pkg::IDX_ZERO;
          state_d      = status_i.neg ? S_SIGN : S_SPEC;
        end else if (status_i.gen_ge1) begin
          state_d = S_DIV_CHK;
        end else begin
          state_d = S_DEC;
        end
      end
      S_DIV_CHK: begin
        if (status_i.scan_ge1 && !status_i.idig_full) begin
          cmd_o.div_load = 1'b1;
          cnt_d          = '0;
          state_d        = S_DIV;
        end else begin
          state_d = S_DEC;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(fdt_pkg::DivSteps - 1)) begin
          state_d = S_DIV_RND;
        end
      end
      S_DIV_RND: begin
        cmd_o.div_round = 1'b1;
        state_d         = S_DIV_CHK;
      end
      S_DEC: begin
        cmd_o.dec_set = 1'b1;
        state_d       = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_PRND;
      end
      S_PRND: begin
        cmd_o.prnd = 1'b1;
        state_d    = S_ADD;
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = S_CONV;
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        cnt_d      = '0;
        state_d    = S_BCD;
      end
      S_BCD: begin
        cmd_o.bcd_step = 1'b1;
        cnt_d          = cnt_q + 5'd1;
        if (cnt_q == 5'(fdt_pkg::BcdSteps - 1)) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan   = 1'b1;
        cmd_o.idx_op = fdt_pkg::IDX_HI;
        state_d      = status_i.neg ? S_SIGN : S_WHOLE;
      end
      S_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.emit = fdt_pkg::EMIT_SIGN;
          state_d    = status_i.special ? S_SPEC : S_WHOLE;
        end
      end
      S_SPEC: begin
        if (status_i.out_free) begin
          cmd_o.emit = fdt_pkg::EMIT_SPEC;
          if (status_i.spec_end) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = fdt_pkg::IDX_UP;
          end
        end
      end
      S_WHOLE: begin
        if (status_i.out_free) begin
          cmd_o.emit = fdt_pkg::EMIT_WHOLE;
          if (status_i.idx_at_dec) begin
            state_d = status_i.show_dot ? S_DOT : S_IDLE;
          end else begin
            cmd_o.idx_op = fdt_pkg::IDX_DOWN;
          end
        end
      end
      S_DOT: begin
        if (status_i.out_free) begin
          cmd_o.emit   = fdt_pkg::EMIT_DOT;
          cmd_o.idx_op = fdt_pkg::IDX_DECM1;
          state_d      = S_FRAC;
        end
      end
      S_FRAC: begin
        if (status_i.out_free) begin
          cmd_o.emit = fdt_pkg::EMIT_FRAC;
          if (status_i.idx_at_lo) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.idx_op = fdt_pkg::IDX_DOWN;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while an item is in flight");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam logic OP_FIXED   = 1'b0;
  localparam logic OP_GENERAL = 1'b1;
  localparam int   STALL_LIMIT = 6000;
  localparam int   HOLD_CYCLES = 800;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  fdt_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  fdt_pkg::out_item_t out_data_o;

  fdt_pkg::out_item_t char_q[$];
  int        err_cnt = 0;
  int        quiet_cycles = 0;
  bit        quiet_send = 1'b0;
  bit        quiet_recv = 1'b0;
  bit        hold_req = 1'b0;
  int        hold_left = 0;

  float_to_decimal_text dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Round a nonnegative real to the nearest float32, ties to even,
  // with subnormals and overflow to infinity
  function automatic real round_f32(input real x);
    logic [63:0] b, full, q, rem, half;
    int          e, s;
    real         r;
    if (x == 0.0) return 0.0;
    b    = $realtobits(x);
    e    = int'(b[62:52]) - 1023;
    full = {11'd0, 1'b1, b[51:0]};
    s    = (e >= -126) ? 29 : -(e + 97);
    if (s > 60) return 0.0;
    q    = full >> s;
    rem  = full & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    r = real'(q) * (2.0 ** (e - 52 + s));
    if (r >= 2.0 ** 128) r = $bitstoreal(64'h7FF0_0000_0000_0000);
    return r;
  endfunction

  // Expected character stream of one number
  function automatic void predict_text(input fdt_pkg::in_item_t it);
    logic [6:0]  txt[$];
    logic [6:0]  dq[$];
    logic [30:0] mb;
    logic [63:0] p10, scaled, whole, frac;
    longint      li;
    real         mag, prod, sum, scan;
    int          dec, idig, sig, ex;
    fdt_pkg::out_item_t o;
    mb = it.value_bits[30:0];
    if (mb > 31'h7F80_0000) begin
      txt = '{7'h6E, 7'h61, 7'h6E};
    end else if (mb == 31'h7F80_0000) begin
      if (it.value_bits[31]) txt.push_back(fdt_pkg::CharMinus);
      txt.push_back(7'h69); txt.push_back(7'h6E); txt.push_back(7'h66);
    end else begin
      ex  = int'(mb[30:23]);
      mag = (ex == 0) ? real'(mb[22:0]) * (2.0 ** -149)
                      : real'({1'b1, mb[22:0]}) * (2.0 ** (ex - 150));
      if (it.operation == OP_GENERAL) begin
        sig = (it.digit_count < 1) ? 1 : (it.digit_count > 9) ? 9 : int'(it.digit_count);
        idig = 1;
        if (mag >= 1.0) begin
          scan = mag;
          idig = 0;
          while (scan >= 1.0 && idig < 12) begin
            scan = round_f32(scan / 10.0);
            idig++;
          end
        end
        dec = sig - idig;
      end else begin
        dec = int'(it.digit_count);
      end
      if (dec < 0) dec = 0;
      if (dec > 9) dec = 9;
      p10 = 64'd1;
      repeat (dec) p10 = p10 * 64'd10;
      prod = round_f32(mag * real'(p10));
      sum  = round_f32(prod + 0.5);
      if (sum >= 2.0 ** 63) begin
        scaled = 64'h7FFF_FFFF_FFFF_FFFF;
      end else begin
        li = longint'(sum);
        if (real'(li) > sum) li--;
        scaled = li;
      end
      whole = scaled / p10;
      frac  = scaled % p10;
      if (it.value_bits[31] && mb != 0) txt.push_back(fdt_pkg::CharMinus);
      do begin
        dq.push_front(fdt_pkg::CharZero + 7'(whole % 10));
        whole = whole / 10;
      end while (whole != 0);
      foreach (dq[i]) txt.push_back(dq[i]);
      if (dec > 0) begin
        txt.push_back(fdt_pkg::CharDot);
        dq.delete();
        repeat (dec) begin
          dq.push_front(fdt_pkg::CharZero + 7'(frac % 10));
          frac = frac / 10;
        end
        foreach (dq[i]) txt.push_back(dq[i]);
        if (it.operation == OP_GENERAL) begin
          while (txt[$] == fdt_pkg::CharZero) void'(txt.pop_back());
          if (txt[$] == fdt_pkg::CharDot) void'(txt.pop_back());
        end
      end
    end
    foreach (txt[i]) begin
      o.character = txt[i];
      o.last      = (i == txt.size() - 1);
      char_q.push_back(o);
    end
  endfunction

  // Offer one number; returns after the beat is taken
  task automatic send_number(input logic [31:0] bits, input logic op, input logic [3:0] cnt);
    fdt_pkg::in_item_t it;
    int                gap;
    it = '{value_bits: bits, operation: op, digit_count: cnt};
    gap = 0;
    if (!quiet_send && $urandom_range(0, 99) < 31) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_text(it);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55)
      return {1'($urandom), 8'($urandom_range(100, 160)), 23'($urandom)};
    else if (k < 75)
      return $urandom;
    else if (k < 85)
      return {1'($urandom), 8'($urandom_range(127, 140)), 23'($urandom) & 23'h7F_C000};
    else if (k < 92)
      return {1'($urandom), 8'hFF, ($urandom_range(0, 1) ? 23'd0 : 23'($urandom))};
    else
      return {1'($urandom), 8'($urandom_range(0, 2)), 23'($urandom)};
  endfunction

  // Extremes, special values and rounding edges
  task automatic test_directed();
    send_number(32'h0000_0000, OP_FIXED, 4'd3);
    send_number(32'h8000_0000, OP_FIXED, 4'd2);
    send_number(32'h8000_0000, OP_GENERAL, 4'd5);
    send_number(32'h7FC0_0000, OP_FIXED, 4'd0);
    send_number(32'hFFFF_FFFF, OP_GENERAL, 4'd15);
    send_number(32'h7F80_0000, OP_FIXED, 4'd1);
    send_number(32'hFF80_0000, OP_GENERAL, 4'd1);
    send_number(32'h3F80_0000, OP_FIXED, 4'd0);
    send_number(32'h3F80_0000, OP_FIXED, 4'd15);
    send_number(32'h7F7F_FFFF, OP_FIXED, 4'd9);
    send_number(32'hFF7F_FFFF, OP_GENERAL, 4'd9);
    send_number(32'h0000_0001, OP_FIXED, 4'd9);
    send_number(32'h3F00_0000, OP_FIXED, 4'd0);
    send_number(32'h4020_0000, OP_FIXED, 4'd0);
    send_number(32'h42F6_E979, OP_GENERAL, 4'd0);
    send_number(32'h42F6_E979, OP_GENERAL, 4'd4);
    send_number(32'h42F6_E979, OP_GENERAL, 4'd9);
    send_number(32'h42F6_E979, OP_GENERAL, 4'd15);
    send_number(32'h5368_D4A5, OP_GENERAL, 4'd9);
    send_number(32'h411F_FFFF, OP_GENERAL, 4'd1);
    send_number(32'hBFC0_0000, OP_GENERAL, 4'd2);
    send_number(32'h3DCC_CCCD, OP_GENERAL, 4'd3);
    send_number(32'h4B00_0001, OP_FIXED, 4'd1);
  endtask

  task automatic test_random(input int n);
    repeat (n) send_number(pick_value(), 1'($urandom), 4'($urandom));
  endtask

  // Receiver holds off while numbers keep coming
  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (6) send_number(pick_value(), 1'($urandom), 4'($urandom));
  endtask

  // Both sides at full rate
  task automatic test_full_rate();
    quiet_send = 1'b1;
    quiet_recv = 1'b1;
    repeat (25) send_number(pick_value(), 1'($urandom), 4'($urandom));
    quiet_send = 1'b0;
    quiet_recv = 1'b0;
  endtask

  // Receiver ready pattern
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (quiet_recv) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 31);
    end
  end

  // Compare each character beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (char_q.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat char=%h last=%b", $time,
                 out_data_o.character, out_data_o.last);
      end else begin
        if (out_data_o.character !== char_q[0].character) begin
          err_cnt++;
          $display("%0t: character expected %h actual %h", $time,
                   char_q[0].character, out_data_o.character);
        end
        if (out_data_o.last !== char_q[0].last) begin
          err_cnt++;
          $display("%0t: last expected %b actual %b", $time,
                   char_q[0].last, out_data_o.last);
        end
        void'(char_q.pop_front());
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(55);
    test_backpressure();
    test_full_rate();
    test_random(55);
    in_valid_i <= 1'b0;
    while (char_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### float_to_decimal_text.f
rtl/fdt_pkg.sv
rtl/fdt_datapath.sv
rtl/fdt_ctrl.sv
rtl/float_to_decimal_text.sv
tb/tb_top.sv
